### src/khb_pkg.sv
// Shared types and constants for the kernel heap break / frame allocator.
// No dependencies.
package khb_pkg;

    // Default sizes
    localparam int MAX_FRAMES_DEF   = 1024;
    localparam int REGION_PAGES_DEF = 128;
    localparam int PAGE_SHIFT_DEF   = 13;

    // Field widths fixed by the interface
    localparam int CMD_W   = 3;
    localparam int FRAME_W = 10;
    localparam int STS_W   = 2;
    localparam int PAGE_W  = 8;
    localparam int ADDR_W  = 32;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 3'd0,
        CMD_ALLOC = 3'd1,
        CMD_FREE  = 3'd2,
        CMD_USE   = 3'd3,
        CMD_BRK   = 3'd4
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_BELOW = 2'd1,
        ST_STACK = 2'd2,
        ST_NOMEM = 2'd3
    } t_status;

    typedef enum logic [CIDX_W-1:0] {
        CFG_FRAME_COUNT = 3'd0,
        CFG_ORIG_HEAP   = 3'd1,
        CFG_FIRST_DATA  = 3'd2,
        CFG_HEAP_LIMIT  = 3'd3,
        CFG_STACK_FIRST = 3'd4,
        CFG_STACK_COUNT = 3'd5,
        CFG_VM_ON       = 3'd6
    } t_cfg_idx;

endpackage

### src/kernel_heap_break_frame_allocator_top.sv
// Kernel heap break / frame allocator top level: sequencer, page map and frame map.
// Depends on khb_pkg and khb_ram.
//
// One request at a time; a result always follows each request. After reset the
// frame map is swept clear, during which no request is taken. Init repeats the
// same sweep and then maps the kernel text, data and stack pages one at a time.
// Allocate scans the frame map through its single read port, reading and then
// checking each frame in turn. Free and use write one frame map entry.
// Set-break frees the frame of each mapped page above the new break in turn when
// lowering, skipping unmapped pages, and runs a full allocate scan per page when raising.
module kernel_heap_break_frame_allocator_top
    import khb_pkg::*;
#(
    parameter int MAX_FRAMES   = MAX_FRAMES_DEF,
    parameter int REGION_PAGES = REGION_PAGES_DEF,
    parameter int PAGE_SHIFT   = PAGE_SHIFT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [FRAME_W-1:0] i_frame_number,
    input  logic [ADDR_W-1:0]  i_break_address,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FRAME_W-1:0] o_granted_frame,
    output logic [STS_W-1:0]   o_status,
    output logic [PAGE_W-1:0]  o_break_page_now
);

    localparam int FW = $clog2(MAX_FRAMES);
    localparam int PW = $clog2(REGION_PAGES);
    localparam int NW = ADDR_W - PAGE_SHIFT;
    localparam int LW = (FW + 1 > CFG_W) ? FW + 1 : CFG_W;
    localparam int CW = ((PW > PAGE_W) ? PW : PAGE_W) + 1;
    localparam int MX = ((FW > PAGE_W) ? FW : PAGE_W) + 1;
    localparam int M2 = ((FW > FRAME_W) ? FW : FRAME_W) + 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_INIT_CLR, S_INIT_TXT, S_INIT_STK, S_MARK, S_BRK,
        S_SCAN_RD, S_SCAN_CHK, S_GROW, S_SHR_CHK, S_SHR_FREE, S_FIN
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [CFG_W-1:0]  r_fc;
    logic [PAGE_W-1:0] r_ohp, r_hlp;
    logic [6:0]        r_sfp;
    logic [3:0]        r_spc;
    logic              r_vm;

    // request and working registers
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [FRAME_W-1:0] r_frm, n_frm;
    logic [NW-1:0]      r_np, n_np;
    logic [FW:0]        r_f, n_f;
    logic [PAGE_W-1:0]  r_p, n_p;
    logic [3:0]         r_k, n_k;
    logic               r_grow, n_grow;
    logic [REGION_PAGES-1:0] r_vld, n_vld;
    logic [PAGE_W-1:0]  r_brk, n_brk;
    logic [FRAME_W-1:0] r_gnt, n_gnt;
    logic [STS_W-1:0]   r_sts, n_sts;

    // result register
    logic               r_ovld, n_ovld;
    logic [FRAME_W-1:0] r_ognt, n_ognt;
    logic [STS_W-1:0]   r_osts, n_osts;
    logic [PAGE_W-1:0]  r_obrk, n_obrk;

    // RAM ports
    logic               fr_we;
    logic [FW-1:0]      fr_waddr, fr_raddr;
    logic [0:0]         fr_wdata, fr_rdata;
    logic               mf_we;
    logic [PW-1:0]      mf_waddr, mf_raddr;
    logic [FRAME_W-1:0] mf_rdata;

    logic [LW-1:0] lim;
    logic          p_in_reg;
    logic [PW-1:0] p_idx;
    logic [PAGE_W-1:0] np8;

    khb_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_frame_map (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (fr_wdata),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    khb_ram #(.WIDTH(FRAME_W), .DEPTH(REGION_PAGES)) u_page_frame (
        .i_clk   (i_clk),
        .i_we    (mf_we),
        .i_waddr (mf_waddr),
        .i_wdata (FRAME_W'(mf_we && (r_state == S_GROW || r_state == S_SCAN_CHK)
                          ? r_f : LW'(r_p))),
        .i_raddr (mf_raddr),
        .o_rdata (mf_rdata)
    );

    assign lim = (LW'(r_fc) < LW'(MAX_FRAMES)) ? LW'(r_fc) : LW'(MAX_FRAMES);
    assign p_in_reg = CW'(r_p) < CW'(REGION_PAGES);
    assign p_idx = PW'(r_p);
    assign np8 = PAGE_W'(r_np);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc  <= CFG_W'(1024);
            r_ohp <= PAGE_W'(16);
            r_hlp <= PAGE_W'(126);
            r_sfp <= 7'd126;
            r_spc <= 4'd2;
            r_vm  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_COUNT: r_fc  <= i_cfg_data;
                CFG_ORIG_HEAP:   r_ohp <= i_cfg_data[PAGE_W-1:0];
                CFG_HEAP_LIMIT:  r_hlp <= i_cfg_data[PAGE_W-1:0];
                CFG_STACK_FIRST: r_sfp <= i_cfg_data[6:0];
                CFG_STACK_COUNT: r_spc <= i_cfg_data[3:0];
                CFG_VM_ON:       r_vm  <= i_cfg_data[0];
                // protection is not kept, so the data page boundary has no effect
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;  n_frm = r_frm;  n_np = r_np;
        n_f = r_f;  n_p = r_p;  n_k = r_k;  n_grow = r_grow;
        n_vld = r_vld;  n_brk = r_brk;  n_gnt = r_gnt;  n_sts = r_sts;
        n_ognt = r_ognt;  n_osts = r_osts;  n_obrk = r_obrk;
        n_ovld = (r_ovld && !i_out_stall) ? 1'b0 : r_ovld;
        fr_we = 1'b0;  fr_waddr = FW'(r_f);  fr_wdata = 1'b0;
        fr_raddr = FW'(r_f);
        mf_we = 1'b0;  mf_waddr = p_idx;  mf_raddr = p_idx;

        unique case (r_state)
            S_CLR, S_INIT_CLR: begin
                fr_we = 1'b1;
                n_f = r_f + 1'b1;
                if (FW'(r_f) == FW'(MAX_FRAMES - 1)) begin
                    n_f = '0;
                    n_p = '0;
                    n_vld = '0;
                    n_state = (r_state == S_CLR) ? S_IDLE : S_INIT_TXT;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_command;
                    n_frm = i_frame_number;
                    n_np = NW'(i_break_address >> PAGE_SHIFT);
                    n_gnt = '0;
                    n_sts = ST_OK;
                    n_f = '0;
                    unique case (i_command)
                        CMD_INIT:  n_state = S_INIT_CLR;
                        CMD_ALLOC: begin
                            n_grow = 1'b0;
                            n_state = S_SCAN_RD;
                        end
                        CMD_FREE, CMD_USE: n_state = S_MARK;
                        CMD_BRK:   n_state = S_BRK;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            // kernel text and data pages, identity mapped
            S_INIT_TXT: begin
                if (r_p < r_ohp && p_in_reg) begin
                    mf_we = 1'b1;
                    n_vld[p_idx] = 1'b1;
                    fr_we = MX'(r_p) < MX'(MAX_FRAMES);
                    fr_waddr = FW'(r_p);
                    fr_wdata = 1'b1;
                    n_p = r_p + 1'b1;
                end else begin
                    n_p = PAGE_W'(r_sfp);
                    n_k = '0;
                    n_state = S_INIT_STK;
                end
            end
            // kernel stack pages
            S_INIT_STK: begin
                if (r_k < r_spc && p_in_reg) begin
                    mf_we = 1'b1;
                    n_vld[p_idx] = 1'b1;
                    fr_we = MX'(r_p) < MX'(MAX_FRAMES);
                    fr_waddr = FW'(r_p);
                    fr_wdata = 1'b1;
                    n_p = r_p + 1'b1;
                    n_k = r_k + 1'b1;
                end else begin
                    n_brk = r_hlp;
                    n_state = S_FIN;
                end
            end
            S_MARK: begin
                fr_we = M2'(r_frm) < M2'(MAX_FRAMES);
                fr_waddr = FW'(r_frm);
                fr_wdata = (r_cmd == CMD_USE);
                n_state = S_FIN;
            end
            S_BRK: begin
                if (r_np < NW'(r_ohp)) begin
                    n_sts = ST_BELOW;
                    n_state = S_FIN;
                end else if (!r_vm) begin
                    n_state = S_FIN;
                end else if (r_np > NW'(r_hlp)) begin
                    n_sts = ST_STACK;
                    n_state = S_FIN;
                end else if (np8 <= r_brk) begin
                    n_p = np8;
                    n_state = S_SHR_CHK;
                end else begin
                    n_p = r_brk;
                    n_grow = 1'b1;
                    n_state = S_GROW;
                end
            end
            // first-fit scan, reading and then checking one frame at a time
            S_SCAN_RD: begin
                if (LW'(r_f) < lim) begin
                    n_state = S_SCAN_CHK;
                end else begin
                    n_sts = ST_NOMEM;
                    n_state = S_FIN;
                end
            end
            S_SCAN_CHK: begin
                if (!fr_rdata[0]) begin
                    fr_we = 1'b1;
                    fr_wdata = 1'b1;
                    if (r_grow) begin
                        mf_we = p_in_reg;
                        if (p_in_reg) begin
                            n_vld[p_idx] = 1'b1;
                        end
                        n_p = r_p + 1'b1;
                        n_state = S_GROW;
                    end else begin
                        n_gnt = FRAME_W'(r_f);
                        n_state = S_FIN;
                    end
                end else begin
                    n_f = r_f + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_GROW: begin
                n_f = '0;
                if (r_p < np8) begin
                    n_state = S_SCAN_RD;
                end else begin
                    n_brk = np8;
                    n_state = S_FIN;
                end
            end
            // lowering: free frames of valid pages above the new break
            S_SHR_CHK: begin
                if (r_p < r_brk && p_in_reg) begin
                    if (r_vld[p_idx]) begin
                        n_state = S_SHR_FREE;
                    end else begin
                        n_p = r_p + 1'b1;
                    end
                end else begin
                    n_brk = np8;
                    n_state = S_FIN;
                end
            end
            S_SHR_FREE: begin
                fr_we = M2'(mf_rdata) < M2'(MAX_FRAMES);
                fr_waddr = FW'(mf_rdata);
                fr_wdata = 1'b0;
                n_vld[p_idx] = 1'b0;
                n_p = r_p + 1'b1;
                n_state = S_SHR_CHK;
            end
            S_FIN: begin
                if (!r_ovld || !i_out_stall) begin
                    n_ovld = 1'b1;
                    n_ognt = r_gnt;
                    n_osts = r_sts;
                    n_obrk = r_brk;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_f     <= '0;
            r_vld   <= '0;
            r_brk   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_f     <= n_f;
            r_vld   <= n_vld;
            r_brk   <= n_brk;
            r_ovld  <= n_ovld;
        end
        r_cmd  <= n_cmd;
        r_frm  <= n_frm;
        r_np   <= n_np;
        r_p    <= n_p;
        r_k    <= n_k;
        r_grow <= n_grow;
        r_gnt  <= n_gnt;
        r_sts  <= n_sts;
        r_ognt <= n_ognt;
        r_osts <= n_osts;
        r_obrk <= n_obrk;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ovld;
    assign o_granted_frame  = r_ognt;
    assign o_status         = r_osts;
    assign o_break_page_now = r_obrk;

    // a granted frame only comes with an ok status
    a_gnt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted_frame != '0) |-> (o_status == ST_OK))
        else $error("nonzero frame with error status");

    // a new result only leaves the finish state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result without finish");

    // the scan never looks past the configured frames
    a_scan_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> (LW'(r_f) < lim))
        else $error("scan beyond frame limit");

endmodule

### src/khb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module khb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### tb/sv/kernel_heap_break_frame_allocator_top_test.sv
// Self-checking testbench for the kernel heap break / frame allocator.
// Depends on khb_pkg and the kernel_heap_break_frame_allocator_top RTL.
// A frame/page map mirror predicts each result; random input gaps and output stalls.
module kernel_heap_break_frame_allocator_top_test
    import khb_pkg::*;
();

    localparam int NFRAMES = MAX_FRAMES_DEF;
    localparam int NPAGES  = REGION_PAGES_DEF;
    localparam int PSHIFT  = PAGE_SHIFT_DEF;
    localparam logic [2:0] PROT_RX = 3'd5;
    localparam logic [2:0] PROT_RW = 3'd3;

    typedef struct packed {
        logic [FRAME_W-1:0] granted;
        logic [STS_W-1:0]   status;
        logic [PAGE_W-1:0]  brk;
    } t_answer;

    // Mirror of allocator state plus the queue of answers still owed
    class allocator_scoreboard;
        int unsigned frame_count, orig_heap, first_data, heap_limit;
        int unsigned stack_first, stack_count, vm_on;
        bit          frame_used[NFRAMES];
        bit          page_valid[NPAGES];
        int unsigned page_frame[NPAGES];
        logic [2:0]  page_prot[NPAGES];
        int unsigned break_page;
        t_answer     owed_answers[$];
        int          errors;

        function void set_reg(t_cfg_idx idx, int unsigned v);
            case (idx)
                CFG_FRAME_COUNT: frame_count = v & 11'h7ff;
                CFG_ORIG_HEAP:   orig_heap   = v & 8'hff;
                CFG_FIRST_DATA:  first_data  = v & 8'hff;
                CFG_HEAP_LIMIT:  heap_limit  = v & 8'hff;
                CFG_STACK_FIRST: stack_first = v & 7'h7f;
                CFG_STACK_COUNT: stack_count = v & 4'hf;
                CFG_VM_ON:       vm_on       = v & 1;
                default: ;
            endcase
        endfunction

        function void clear();
            frame_count = 1024; orig_heap = 16; first_data = 8; heap_limit = 126;
            stack_first = 126; stack_count = 2; vm_on = 0; break_page = 0;
            foreach (frame_used[f]) frame_used[f] = 0;
            foreach (page_valid[p]) page_valid[p] = 0;
            errors = 0;
        endfunction

        // first fit over the configured frames
        function bit grab_frame(output int unsigned got);
            int unsigned lim;
            lim = (frame_count < NFRAMES) ? frame_count : NFRAMES;
            got = 0;
            for (int unsigned f = 0; f < lim; f++) begin
                if (!frame_used[f]) begin
                    frame_used[f] = 1;
                    got = f;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void map_page(int unsigned p, int unsigned f, logic [2:0] prot);
            if (p >= NPAGES) return;
            page_valid[p] = 1;
            page_frame[p] = f & 10'h3ff;
            page_prot[p]  = prot;
        endfunction

        function void mark(int unsigned f, bit v);
            if (f < NFRAMES) frame_used[f] = v;
        endfunction

        function void boot_map();
            foreach (frame_used[f]) frame_used[f] = 0;
            foreach (page_valid[p]) page_valid[p] = 0;
            for (int unsigned p = 0; p < orig_heap && p < NPAGES; p++) begin
                map_page(p, p, (p < first_data) ? PROT_RX : PROT_RW);
                mark(p, 1);
            end
            for (int unsigned p = stack_first; p < stack_first + stack_count; p++) begin
                if (p >= NPAGES) break;
                map_page(p, p, PROT_RW);
                mark(p, 1);
            end
            break_page = heap_limit;
        endfunction

        function t_status move_break(logic [ADDR_W-1:0] addr);
            int unsigned np, f;
            np = addr >> PSHIFT;
            if (np < orig_heap) return ST_BELOW;
            if (!vm_on) return ST_OK;
            if (np > heap_limit) return ST_STACK;
            if (np <= break_page) begin
                // shrink: release the frames of mapped pages only
                for (int unsigned p = np; p < break_page && p < NPAGES; p++) begin
                    if (page_valid[p]) begin
                        mark(page_frame[p], 0);
                        page_valid[p] = 0;
                    end
                end
            end else begin
                // grow: every page takes a frame, even past the region
                for (int unsigned p = break_page; p < np; p++) begin
                    if (!grab_frame(f)) return ST_NOMEM;
                    map_page(p, f, PROT_RW);
                end
            end
            break_page = np;
            return ST_OK;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frm,
                                   logic [ADDR_W-1:0] addr);
            t_answer a;
            int unsigned f;
            a.granted = '0;
            a.status  = ST_OK;
            case (cmd)
                CMD_INIT:  boot_map();
                CMD_ALLOC: if (grab_frame(f)) a.granted = f; else a.status = ST_NOMEM;
                CMD_FREE:  mark(frm, 0);
                CMD_USE:   mark(frm, 1);
                CMD_BRK:   a.status = move_break(addr);
                default: ;
            endcase
            a.brk = break_page;
            owed_answers.push_back(a);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(logic [FRAME_W-1:0] g, logic [STS_W-1:0] s, logic [PAGE_W-1:0] b);
            t_answer a;
            if (owed_answers.size() == 0) begin
                report_mismatch("unexpected result, frame", g, 0);
                return;
            end
            a = owed_answers.pop_front();
            if (g !== a.granted) report_mismatch("granted_frame", g, a.granted);
            if (s !== a.status)  report_mismatch("status", s, a.status);
            if (b !== a.brk)     report_mismatch("break_page_now", b, a.brk);
        endtask
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [CIDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic [CMD_W-1:0]   i_command = '0;
    logic [FRAME_W-1:0] i_frame_number = '0;
    logic [ADDR_W-1:0]  i_break_address = '0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic [FRAME_W-1:0] o_granted_frame;
    logic [STS_W-1:0]   o_status;
    logic [PAGE_W-1:0]  o_break_page_now;

    allocator_scoreboard sb = new();
    bit quiet;          // phase without idling on either side
    int stall_left;

    kernel_heap_break_frame_allocator_top i_dut (.*);

    always #1 i_clk = ~i_clk;

    // result side: check accepted results, then draw the next stall stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_granted_frame, o_status, o_break_page_now);
            stall_left = quiet ? 0 : $urandom_range(0, 19);
            i_out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= (stall_left != 0);
        end
    end

    task send_request(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frm,
                      logic [ADDR_W-1:0] addr);
        int gap;
        i_in_valid      <= 1;
        i_command       <= cmd;
        i_frame_number  <= frm;
        i_break_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(cmd, frm, addr);
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task drain();
        if (i_in_valid) begin
            @(posedge i_clk);
            i_in_valid <= 0;
        end
        while (sb.owed_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_regs(int unsigned fc, int unsigned oh, int unsigned fd, int unsigned hl,
                    int unsigned sf, int unsigned sc, int unsigned vm);
        int unsigned vals[7];
        vals = '{fc, oh, fd, hl, sf, sc, vm};
        drain();
        for (int i = 0; i < 7; i++) begin
            i_cfg_we    <= 1;
            i_cfg_index <= i;
            i_cfg_data  <= vals[i];
            sb.set_reg(t_cfg_idx'(i), vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    function logic [ADDR_W-1:0] page_addr(int unsigned pg);
        return (ADDR_W'(pg) << PSHIFT) | ADDR_W'($urandom_range(0, (1 << PSHIFT) - 1));
    endfunction

    // mostly well-formed traffic around the configured break window
    task random_traffic(int n);
        int unsigned pick, top, lo;
        logic [CMD_W-1:0] cmd;
        logic [FRAME_W-1:0] frm;
        logic [ADDR_W-1:0] addr;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)       cmd = CMD_INIT;
            else if (pick < 34) cmd = CMD_ALLOC;
            else if (pick < 50) cmd = CMD_FREE;
            else if (pick < 60) cmd = CMD_USE;
            else if (pick < 96) cmd = CMD_BRK;
            else                cmd = $urandom_range(5, 7);
            top = (sb.frame_count + 4 > 1023) ? 1023 : sb.frame_count + 4;
            frm = ($urandom_range(0, 9) < 8) ? $urandom_range(0, top) : $urandom;
            lo = (sb.orig_heap > 0) ? sb.orig_heap - 1 : 0;
            if ($urandom_range(0, 9) < 8)
                addr = page_addr($urandom_range(lo, sb.heap_limit + 2));
            else
                addr = $urandom;
            send_request(cmd, frm, addr);
        end
    endtask

    initial begin
        sb.clear();
        stall_left = 0;
        quiet = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // commands before any init act on the reset state
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_FREE, 0, 0);
        send_request(CMD_USE, 10'h3ff, 0);
        send_request(CMD_BRK, 0, 32'hffff_ffff);
        send_request(3'd5, 10'h2aa, 32'h5555_5555);

        // tiny frame pool: exhaustion, region edges, every command
        write_regs(8, 16, 8, 126, 126, 2, 1);
        send_request(CMD_INIT, 0, 0);
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_BRK, 0, 32'hffff_ffff);
        send_request(CMD_BRK, 0, page_addr(15));
        send_request(CMD_BRK, 0, page_addr(126));
        send_request(CMD_BRK, 0, page_addr(16));
        send_request(CMD_BRK, 0, page_addr(16));
        send_request(CMD_BRK, 0, page_addr(20));
        send_request(CMD_FREE, 3, 0);
        send_request(CMD_FREE, 10'h3ff, 0);
        send_request(CMD_USE, 10'h3ff, 0);
        send_request(CMD_BRK, 0, page_addr(18));
        send_request(CMD_ALLOC, 0, 0);
        send_request(3'd6, 0, 0);
        send_request(3'd7, 10'h3ff, 32'haaaa_aaaa);
        send_request(CMD_INIT, 0, 0);
        random_traffic(90);

        // paging off: set-break only validates
        write_regs(40, 10, 4, 60, 120, 8, 0);
        send_request(CMD_INIT, 0, 0);
        random_traffic(80);

        // largest pool, full region, stack at the last page
        quiet = 1;
        write_regs(1024, 0, 0, 128, 127, 8, 1);
        send_request(CMD_INIT, 0, 0);
        send_request(CMD_BRK, 0, page_addr(128));
        send_request(CMD_BRK, 0, page_addr(0));
        random_traffic(80);
        quiet = 0;

        // whole region kernel image, zero break limit
        write_regs(64, 128, 128, 0, 0, 1, 1);
        send_request(CMD_INIT, 0, 0);
        random_traffic(80);

        write_regs(200, 20, 5, 90, 100, 4, 1);
        send_request(CMD_INIT, 0, 0);
        random_traffic(90);

        // random settings, mostly small pools
        for (int ph = 0; ph < 7; ph++) begin
            quiet = (ph == 3);
            write_regs($urandom_range(8, 96), $urandom_range(0, 40), $urandom_range(0, 40),
                       $urandom_range(20, 128), $urandom_range(0, 127),
                       $urandom_range(1, 8), ($urandom_range(0, 4) != 0));
            send_request(CMD_INIT, 0, 0);
            random_traffic(85);
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_answers.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
